### hdl/tkn_pkg.sv
// Package with key codes, escape phase type and decode result types for the key normalizer.
`default_nettype none

package tkn_pkg;

  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_TAB    = 8'h09;
  localparam logic [7:0] KEY_BS     = 8'h08;
  localparam logic [7:0] KEY_ESC    = 8'h1B;
  localparam logic [7:0] KEY_RUBOUT = 8'h7F;

  localparam logic [7:0] KEY_UP     = 8'h0B;
  localparam logic [7:0] KEY_DOWN   = 8'h0A;
  localparam logic [7:0] KEY_RIGHT  = 8'h09;
  localparam logic [7:0] KEY_LEFT   = 8'h08;
  localparam logic [7:0] KEY_HOME   = 8'h05;
  localparam logic [7:0] KEY_DEL    = 8'h07;

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_3        = 8'h33;
  localparam logic [7:0] CH_TILDE    = 8'h7E;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2,
    PH_CSI3 = 2'd3
  } tkn_phase_t;

  typedef struct packed {
    logic [1:0] count;
    logic [7:0] code0;
    logic [7:0] code1;
  } tkn_res_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } tkn_ent_t;

endpackage

`default_nettype wire

### hdl/tkn_decode.sv
// Escape sequence state machine and byte decoder for the key normalizer.
`default_nettype none

module tkn_decode
  import tkn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] in_byte,
  input  wire logic       next_waiting,
  output tkn_res_t        res
);

  tkn_phase_t phase_r, phase_nxt;
  logic       swallow_r, swallow_nxt;

  logic       p_emit;
  logic [7:0] p_code;
  logic       p_sw;
  logic       p_esc;

  // Handling of a byte outside any escape sequence.
  always_comb begin
    p_emit = 1'b1;
    p_code = in_byte;
    p_sw   = 1'b0;
    p_esc  = 1'b0;
    unique case (in_byte)
      KEY_CR: begin
        p_code = KEY_CR;
        p_sw   = 1'b1;
      end
      KEY_LF: begin
        p_code = KEY_CR;
        p_emit = !swallow_r;
      end
      KEY_TAB: begin
        p_emit = 1'b0;
      end
      KEY_BS: begin
        p_code = KEY_RUBOUT;
      end
      KEY_ESC: begin
        p_code = KEY_ESC;
        p_emit = !next_waiting;
        p_esc  = next_waiting;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_nxt   = PH_IDLE;
    swallow_nxt = swallow_r;
    unique case (phase_r)
      PH_ESC: begin
        if (in_byte == CH_LBRACKET) begin
          if (next_waiting) phase_nxt = PH_CSI;
        end else begin
          swallow_nxt = p_sw;
          if (p_esc) phase_nxt = PH_ESC;
        end
      end
      PH_CSI: begin
        if ((in_byte == CH_3) && next_waiting) phase_nxt = PH_CSI3;
      end
      PH_CSI3: begin
        if (in_byte != CH_TILDE) begin
          swallow_nxt = p_sw;
          if (p_esc) phase_nxt = PH_ESC;
        end
      end
      PH_IDLE: begin
        swallow_nxt = p_sw;
        if (p_esc) phase_nxt = PH_ESC;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.count = 2'd0;
    res.code0 = p_code;
    res.code1 = p_code;
    unique case (phase_r)
      PH_ESC: begin
        res.code0 = KEY_ESC;
        if (in_byte == CH_LBRACKET) begin
          res.count = next_waiting ? 2'd0 : 2'd1;
        end else begin
          res.count = p_emit ? 2'd2 : 2'd1;
        end
      end
      PH_CSI: begin
        unique case (in_byte)
          CH_A: begin
            res.count = 2'd1;
            res.code0 = KEY_UP;
          end
          CH_B: begin
            res.count = 2'd1;
            res.code0 = KEY_DOWN;
          end
          CH_C: begin
            res.count = 2'd1;
            res.code0 = KEY_RIGHT;
          end
          CH_D: begin
            res.count = 2'd1;
            res.code0 = KEY_LEFT;
          end
          CH_H: begin
            res.count = 2'd1;
            res.code0 = KEY_HOME;
          end
          default: begin
          end
        endcase
      end
      PH_CSI3: begin
        if (in_byte == CH_TILDE) begin
          res.count = 2'd1;
          res.code0 = KEY_DEL;
        end else begin
          res.count = {1'b0, p_emit};
        end
      end
      PH_IDLE: begin
        res.count = {1'b0, p_emit};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      swallow_r <= 1'b0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      swallow_r <= swallow_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/tkn_outq.sv
// Three-entry result queue that holds decoded key codes until the output side takes them.
`default_nettype none

module tkn_outq
  import tkn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire tkn_res_t   res,
  output logic            full,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_key_code,
  output logic            out_last
);

  tkn_ent_t   q_r   [3];
  tkn_ent_t   q_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] base;
  logic       pop;

  always_comb begin
    pop      = (cnt_r != 2'd0) && !out_stall;
    base     = cnt_r - {1'b0, pop};
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = pop ? q_r[2] : q_r[1];
    q_nxt[2] = q_r[2];
    cnt_nxt  = base;
    if (push) begin
      unique case (res.count)
        2'd1: begin
          q_nxt[base] = '{code: res.code0, last: 1'b1};
          cnt_nxt     = base + 2'd1;
        end
        2'd2: begin
          q_nxt[base]         = '{code: res.code0, last: 1'b0};
          q_nxt[base + 2'd1]  = '{code: res.code1, last: 1'b1};
          cnt_nxt             = base + 2'd2;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign full         = cnt_r > 2'd1;
  assign out_valid    = cnt_r != 2'd0;
  assign out_key_code = q_r[0].code;
  assign out_last     = q_r[0].last;

endmodule

`default_nettype wire

### hdl/terminal_key_normalizer.sv
// Top level of the terminal key normalizer: escape decoder feeding a result queue.
// A result is registered in the queue when its byte is accepted and reaches the output once the items ahead are taken.
// Throughput: one byte per cycle while the three-entry queue holds under two items; it stalls input at two or more.
// An ESC followed by an ordinary byte yields two items, taken from the output one after the other.
// Reset (synchronous, active low) returns the decoder to idle, clears the LF swallow
// flag and empties the result queue.
`default_nettype none

module terminal_key_normalizer
  import tkn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_next_waiting,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_key_code,
  output logic            out_last
);

  tkn_res_t res;
  logic     take;

  assign take = in_valid && !in_stall;

  tkn_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .in_byte      (in_byte),
    .next_waiting (in_next_waiting),
    .res          (res)
  );

  tkn_outq u_outq (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (take),
    .res          (res),
    .full         (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_code (out_key_code),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

### hdl/tkn_checker.sv
// Port-level checker for the terminal key normalizer and its bind statement.
`default_nettype none

module tkn_checker
  import tkn_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_byte,
  input wire logic       in_next_waiting,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_key_code,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_code) && $stable(out_last))
    else $error("Stalled output item changed.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("Input stalled with no item waiting on the output.");

  a_pair_esc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_key_code == KEY_ESC)
    else $error("Non-final item is not ESC.");

  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && !out_stall |=> out_valid)
    else $error("Second item of a pair is missing.");

endmodule

bind terminal_key_normalizer tkn_checker u_tkn_checker (.*);

`default_nettype wire

### test/testbench.sv
// Randomized self-checking testbench for the terminal key normalizer with a built-in decoder model.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tkn_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_TAIL   = 150;
  localparam int REPORT_MAX   = 10;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       nw;
  } rx_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_next_waiting = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_key_code;
  logic       out_last;

  rx_byte_t   bytes_to_send[$];
  tkn_ent_t   key_codes_due[$];
  logic [7:0] step_codes[$];
  tkn_phase_t esc_phase = PH_IDLE;
  logic       lf_armed = 1'b0;
  int         mismatches = 0;
  int         send_gap = 0;
  int         stall_left = 0;
  int         cycles = 0;

  terminal_key_normalizer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_next_waiting (in_next_waiting),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_key_code    (out_key_code),
    .out_last        (out_last)
  );

  always #6 clk = ~clk;

  function automatic bit tail_phase();
    return bytes_to_send.size() < QUIET_TAIL;
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic nw);
    rx_byte_t item;
    item.value = value;
    item.nw = nw;
    bytes_to_send.push_back(item);
  endtask

  // A byte outside any escape sequence yields at most one key code.
  function automatic void plain_key(input logic [7:0] b, input logic nw);
    if (b == KEY_CR) begin
      lf_armed = 1'b1;
      step_codes.push_back(KEY_CR);
    end else if (b == KEY_LF) begin
      if (lf_armed) begin
        lf_armed = 1'b0;
      end else begin
        step_codes.push_back(KEY_CR);
      end
    end else begin
      lf_armed = 1'b0;
      if (b == KEY_BS) begin
        step_codes.push_back(KEY_RUBOUT);
      end else if (b == KEY_ESC) begin
        if (nw) begin
          esc_phase = PH_ESC;
        end else begin
          step_codes.push_back(KEY_ESC);
        end
      end else if (b != KEY_TAB) begin
        step_codes.push_back(b);
      end
    end
  endfunction

  function automatic void decode_key_byte(input logic [7:0] b, input logic nw);
    tkn_phase_t phase;
    tkn_ent_t   ent;
    phase = esc_phase;
    esc_phase = PH_IDLE;
    step_codes.delete();
    case (phase)
      PH_ESC: begin
        if (b == CH_LBRACKET) begin
          if (nw) begin
            esc_phase = PH_CSI;
          end else begin
            step_codes.push_back(KEY_ESC);
          end
        end else begin
          step_codes.push_back(KEY_ESC);
          plain_key(b, nw);
        end
      end
      PH_CSI: begin
        case (b)
          CH_A: step_codes.push_back(KEY_UP);
          CH_B: step_codes.push_back(KEY_DOWN);
          CH_C: step_codes.push_back(KEY_RIGHT);
          CH_D: step_codes.push_back(KEY_LEFT);
          CH_H: step_codes.push_back(KEY_HOME);
          CH_3: begin
            if (nw) esc_phase = PH_CSI3;
          end
          default: ;
        endcase
      end
      PH_CSI3: begin
        if (b == CH_TILDE) begin
          step_codes.push_back(KEY_DEL);
        end else begin
          plain_key(b, nw);
        end
      end
      default: plain_key(b, nw);
    endcase
    foreach (step_codes[i]) begin
      ent.code = step_codes[i];
      ent.last = (i == step_codes.size() - 1);
      key_codes_due.push_back(ent);
    end
  endfunction

  always @(posedge clk) begin
    rx_byte_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_key_byte(in_byte, in_next_waiting);
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (bytes_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!tail_phase() && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else begin
          item = bytes_to_send.pop_front();
          in_byte <= item.value;
          in_next_waiting <= item.nw;
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    tkn_ent_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (key_codes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected item: code %h last %b", out_key_code, out_last);
        end else begin
          want = key_codes_due.pop_front();
          if (out_key_code !== want.code || out_last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: expected code %h last %b, got code %h last %b",
                       want.code, want.last, out_key_code, out_last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!tail_phase() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int          start;
    logic [7:0]  fin;
    logic [7:0]  noise;

    send_byte(8'h00, 1'b0);
    send_byte(KEY_CR, 1'b1);
    send_byte(KEY_LF, 1'b0);
    send_byte(KEY_LF, 1'b1);
    send_byte(KEY_TAB, 1'b0);
    send_byte(KEY_BS, 1'b1);
    send_byte(KEY_ESC, 1'b0);
    send_byte(KEY_ESC, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(KEY_ESC, 1'b1);
    send_byte(CH_LBRACKET, 1'b0);
    send_byte(KEY_ESC, 1'b1);
    send_byte(CH_LBRACKET, 1'b1);
    send_byte(CH_A, 1'b0);
    send_byte(KEY_ESC, 1'b1);
    send_byte(CH_LBRACKET, 1'b1);
    send_byte(CH_3, 1'b1);
    send_byte(CH_TILDE, 1'b0);
    send_byte(KEY_ESC, 1'b1);
    send_byte(CH_LBRACKET, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(KEY_ESC, 1'b1);
    send_byte(CH_LBRACKET, 1'b1);
    send_byte(CH_3, 1'b0);
    send_byte(KEY_ESC, 1'b1);
    send_byte(CH_LBRACKET, 1'b1);
    send_byte(CH_3, 1'b1);
    send_byte(KEY_LF, 1'b0);

    start = bytes_to_send.size();
    while (bytes_to_send.size() < start + RANDOM_ITEMS) begin
      noise = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0, 1, 2: send_byte(noise, 1'($urandom_range(0, 1)));
        3: begin
          send_byte(KEY_CR, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 3) != 0) send_byte(KEY_LF, 1'($urandom_range(0, 1)));
        end
        4: begin
          case ($urandom_range(0, 2))
            0: send_byte(KEY_LF, 1'($urandom_range(0, 1)));
            1: send_byte(KEY_TAB, 1'($urandom_range(0, 1)));
            default: send_byte(KEY_BS, 1'($urandom_range(0, 1)));
          endcase
        end
        5, 6, 7: begin
          send_byte(KEY_ESC, 1'b1);
          send_byte(CH_LBRACKET, 1'b1);
          case ($urandom_range(0, 6))
            0: fin = CH_A;
            1: fin = CH_B;
            2: fin = CH_C;
            3: fin = CH_D;
            4: fin = CH_H;
            5: fin = CH_3;
            default: fin = noise;
          endcase
          if (fin == CH_3) begin
            send_byte(CH_3, 1'b1);
            send_byte($urandom_range(0, 2) != 0 ? CH_TILDE : noise,
                      1'($urandom_range(0, 1)));
          end else begin
            send_byte(fin, 1'($urandom_range(0, 1)));
          end
        end
        8: begin
          send_byte(KEY_ESC, $urandom_range(0, 3) != 0);
          case ($urandom_range(0, 2))
            0: send_byte(noise, 1'($urandom_range(0, 1)));
            1: send_byte(CH_LBRACKET, 1'b0);
            default: begin
              send_byte(CH_LBRACKET, 1'b1);
              send_byte(CH_3, 1'b0);
            end
          endcase
        end
        default: begin
          send_byte(KEY_ESC, 1'($urandom_range(0, 1)));
          send_byte(noise, 1'($urandom_range(0, 1)));
        end
      endcase
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (bytes_to_send.size() != 0 || in_valid || key_codes_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && key_codes_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/tkn_pkg.sv
hdl/tkn_decode.sv
hdl/tkn_outq.sv
hdl/terminal_key_normalizer.sv
hdl/tkn_checker.sv
test/testbench.sv
